### rtl/lgg_pkg.sv
// Package for the lift/gamma/gain grade core: widths, constants, log2/exp2 tables.
// No dependencies.
package lgg_pkg;

  localparam int unsigned NumChannels = 3;
  localparam int unsigned FracBits = 12;
  localparam int unsigned SampleW = 16;
  localparam int unsigned RegW = 48;
  localparam int unsigned IdxW = 2;

  localparam logic [IdxW-1:0] RegLift = 2'd0;
  localparam logic [IdxW-1:0] RegGain = 2'd1;
  localparam logic [IdxW-1:0] RegGamma = 2'd2;

  function automatic logic [16:0] log_lut(input logic [4:0] idx);
    logic [16:0] r;
    case (idx)
      5'd0: r = 17'd0;      5'd1: r = 17'd5732;   5'd2: r = 17'd11136;
      5'd3: r = 17'd16248;  5'd4: r = 17'd21098;  5'd5: r = 17'd25711;
      5'd6: r = 17'd30109;  5'd7: r = 17'd34312;  5'd8: r = 17'd38336;
      5'd9: r = 17'd42196;  5'd10: r = 17'd45904; 5'd11: r = 17'd49472;
      5'd12: r = 17'd52911; 5'd13: r = 17'd56228; 5'd14: r = 17'd59434;
      5'd15: r = 17'd62534; 5'd16: r = 17'd65536;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] exp_lut(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0: r = 18'd65536;   5'd1: r = 18'd68438;   5'd2: r = 18'd71468;
      5'd3: r = 18'd74631;   5'd4: r = 18'd77936;   5'd5: r = 18'd81386;
      5'd6: r = 18'd84989;   5'd7: r = 18'd88752;   5'd8: r = 18'd92682;
      5'd9: r = 18'd96785;   5'd10: r = 18'd101070; 5'd11: r = 18'd105545;
      5'd12: r = 18'd110218; 5'd13: r = 18'd115098; 5'd14: r = 18'd120194;
      5'd15: r = 18'd125515; 5'd16: r = 18'd131072;
      default: r = 18'd65536;
    endcase
    return r;
  endfunction

endpackage

### rtl/lgg_div.sv
// Pipelined restoring divider stage: one quotient bit per stage.
// Depends on nothing; used by lgg_lane for floor(lg * 2^F / gamma).
module lgg_div #(
  parameter int unsigned NumW = 36,
  parameter int unsigned DenW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [NumW-1:0] quo,
  output logic [NumW-1:0] rem_q
);
  // Magnitude division, one bit per pipeline stage.
  logic [NumW-1:0] n_s [NumW+1];
  logic [NumW-1:0] r_s [NumW+1];
  logic [DenW-1:0] d_s [NumW];

  always_comb begin
    n_s[0] = num;
    r_s[0] = '0;
    d_s[0] = den;
  end

  for (genvar k = 0; k < NumW; k++) begin : g_st
    logic [NumW:0] trial;
    logic [NumW-1:0] n_next;
    logic [NumW-1:0] r_next;
    always_comb begin
      trial = {r_s[k], n_s[k][NumW-1]} - {{(NumW+1-DenW){1'b0}}, d_s[k]};
      if (!trial[NumW]) begin
        r_next = trial[NumW-1:0];
        n_next = {n_s[k][NumW-2:0], 1'b1};
      end else begin
        r_next = {r_s[k][NumW-2:0], n_s[k][NumW-1]};
        n_next = {n_s[k][NumW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[k+1] <= n_next;
        r_s[k+1] <= r_next;
      end
    end
    // The last stage needs no divisor copy.
    if (k < NumW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) d_s[k+1] <= d_s[k];
      end
    end
  end

  assign quo = n_s[NumW];
  assign rem_q = r_s[NumW];
endmodule

### rtl/lgg_lane.sv
// One channel lane: linear grade, log2, divide by gamma, exp2, saturate.
// Depends on lgg_pkg and lgg_div. Stalls as a whole on en.
module lgg_lane
  import lgg_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBits
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] lift,
  input  logic signed [15:0] gain,
  input  logic        [15:0] gamma,
  output logic signed [15:0] result
);
  localparam int unsigned NumW = 36;
  localparam logic signed [17:0] One = 18'sd1 <<< FRAC_BITS;

  // Stage 1: products.
  logic signed [33:0] p_gain, p_lift;
  logic [15:0] g1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_gain <= 34'(sample * gain);
      p_lift <= 34'(lift * (One - 18'(sample)));
      g1 <= gamma;
    end
  end

  // Stage 2: round and saturate.
  logic signed [34:0] acc;
  logic signed [34:0] rnd;
  logic signed [15:0] v2;
  logic [15:0] g2;
  always_comb begin
    acc = 35'(p_gain) + 35'(p_lift) + (35'sd1 <<< (FRAC_BITS - 1));
    rnd = acc >>> FRAC_BITS;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (rnd > 35'sd32767) v2 <= 16'sd32767;
      else if (rnd < -35'sd32768) v2 <= -16'sd32768;
      else v2 <= rnd[15:0];
      g2 <= g1;
    end
  end

  // Stage 3: leading one and mantissa.
  logic [3:0] p_c;
  logic [14:0] m_c;
  always_comb begin
    p_c = '0;
    for (int b = 1; b < 15; b++) if (v2[b]) p_c = 4'(b);
    m_c = 15'(v2[14:0] << (4'd15 - p_c)) ;
  end
  logic [3:0] p3;
  logic [14:0] f3;
  logic signed [15:0] v3;
  logic [15:0] g3;
  logic pw3;
  always_ff @(posedge clk) begin
    if (en) begin
      p3 <= p_c;
      f3 <= m_c;
      v3 <= v2;
      g3 <= g2;
      pw3 <= (v2 > 16'sd0) && (g2 != 16'd0);
    end
  end

  // Stage 4: log2 interpolation.
  logic [4:0] li;
  logic [16:0] l0, l1;
  logic [27:0] lprod;
  logic signed [NumW-1:0] lg_c;
  always_comb begin
    li = {1'b0, f3[14:11]};
    l0 = log_lut(li);
    l1 = log_lut(li + 5'd1);
    lprod = 28'(l1 - l0) * 28'(f3[10:0]);
    lg_c = (NumW'(signed'({1'b0, p3})) - NumW'(FRAC_BITS)) * 65536
           + NumW'(l0) + NumW'(lprod >> 11);
  end
  logic signed [NumW-1:0] lg4;
  logic signed [15:0] v4;
  logic [15:0] g4;
  logic pw4;
  always_ff @(posedge clk) begin
    if (en) begin
      lg4 <= lg_c;
      v4 <= v3;
      g4 <= g3;
      pw4 <= pw3;
    end
  end

  // Divide magnitude; floor correction afterwards.
  logic neg4;
  logic [NumW-1:0] mag4;
  assign neg4 = lg4[NumW-1];
  assign mag4 = NumW'((neg4 ? -lg4 : lg4) <<< FRAC_BITS);
  logic [NumW-1:0] quo, rem_q;
  lgg_div #(.NumW(NumW), .DenW(16)) u_div (
    .clk(clk), .en(en), .num(mag4), .den(g4), .quo(quo), .rem_q(rem_q)
  );
  logic neg_d [NumW+1];
  logic signed [15:0] v_d [NumW+1];
  logic pw_d [NumW+1];
  always_comb begin
    neg_d[0] = neg4; v_d[0] = v4; pw_d[0] = pw4;
  end
  for (genvar k = 0; k < NumW; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        neg_d[k+1] <= neg_d[k];
        v_d[k+1] <= v_d[k];
        pw_d[k+1] <= pw_d[k];
      end
    end
  end

  // Stage 5: signed floor quotient, split to n and t.
  logic signed [NumW:0] y_c;
  always_comb begin
    if (!neg_d[NumW]) y_c = {1'b0, quo};
    else if (rem_q != '0) y_c = -$signed({1'b0, quo}) - 1;
    else y_c = -$signed({1'b0, quo});
  end
  logic signed [NumW-16:0] n5;
  logic [15:0] t5;
  logic signed [15:0] v5;
  logic pw5;
  always_ff @(posedge clk) begin
    if (en) begin
      n5 <= y_c[NumW:16];
      t5 <= y_c[15:0];
      v5 <= v_d[NumW];
      pw5 <= pw_d[NumW];
    end
  end

  // Stage 6: exp2 interpolation.
  logic [4:0] ej;
  logic [17:0] e0, e1;
  logic [29:0] eprod;
  logic [17:0] e_c;
  always_comb begin
    ej = {1'b0, t5[15:12]};
    e0 = exp_lut(ej);
    e1 = exp_lut(ej + 5'd1);
    eprod = 30'(e1 - e0) * 30'(t5[11:0]);
    e_c = e0 + 18'(eprod >> 12);
  end
  logic [17:0] e6;
  logic signed [NumW-16:0] s6;
  logic signed [15:0] v6;
  logic pw6;
  always_ff @(posedge clk) begin
    if (en) begin
      e6 <= e_c;
      s6 <= n5 + (NumW-15)'(FRAC_BITS) - (NumW-15)'(16);
      v6 <= v5;
      pw6 <= pw5;
    end
  end

  // Stage 7: scale and saturate.
  logic [5:0] sh;
  logic [57:0] up, dn;
  logic signed [15:0] pw_res;
  always_comb begin
    sh = 6'(s6 >= 0 ? s6 : -s6);
    up = 58'(e6) << sh[3:0];
    dn = (58'(e6) + (58'd1 << (sh - 6'd1))) >> sh;
    if (s6 >= 0) begin
      if (s6 > 15 || up > 58'd32767) pw_res = 16'sd32767;
      else pw_res = up[15:0];
    end else if (s6 <= -40) begin
      pw_res = 16'sd0;
    end else begin
      pw_res = (dn > 58'd32767) ? 16'sd32767 : dn[15:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) result <= pw6 ? pw_res : v6;
  end
endmodule

### rtl/lift_gamma_gain_grade_core.sv
// Lift/gain/gamma grade top level: config registers, lanes, valid pipeline.
// Depends on lgg_pkg and lgg_lane.
//
// Takes one RGB word per cycle and returns one graded word per cycle.
// Latency is set by the per-lane pipeline, most of it in the
// one-bit-per-stage gamma divider. The pipeline advances whenever its last
// stage is empty or being taken, so ready drops only under output stall.
module lift_gamma_gain_grade_core
  import lgg_pkg::*;
#(
  parameter int unsigned CHANNELS = NumChannels,
  parameter int unsigned FRAC_BITS = FracBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IdxW-1:0]    cfg_index,
  input  logic [RegW-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] red_in,
  input  logic signed [15:0] green_in,
  input  logic signed [15:0] blue_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] red_out,
  output logic signed [15:0] green_out,
  output logic signed [15:0] blue_out
);
  localparam int unsigned Lat = 43;
  localparam logic [15:0] OneQ = 16'(1 << FRAC_BITS);

  logic [RegW-1:0] lift_rgb, gain_rgb, gamma_rgb;
  always_ff @(posedge clk) begin
    if (rst) begin
      lift_rgb <= '0;
      gain_rgb <= {OneQ, OneQ, OneQ};
      gamma_rgb <= {OneQ, OneQ, OneQ};
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegLift: lift_rgb <= cfg_data;
        RegGain: gain_rgb <= cfg_data;
        RegGamma: gamma_rgb <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Lat-1:0] vld;
  assign en = !vld[Lat-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[Lat-1];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_valid};
  end

  logic signed [15:0] smp [3];
  logic signed [15:0] res [3];
  assign smp[0] = red_in;
  assign smp[1] = green_in;
  assign smp[2] = blue_in;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      lgg_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .en(en), .sample(smp[c]),
        .lift(lift_rgb[16*c +: 16]), .gain(gain_rgb[16*c +: 16]),
        .gamma(gamma_rgb[16*c +: 16]), .result(res[c])
      );
    end else begin : g_off
      // Pass the raw sample down a matching delay line.
      logic signed [15:0] dl [Lat];
      always_ff @(posedge clk) begin
        if (en) begin
          dl[0] <= smp[c];
          for (int k = 1; k < Lat; k++) dl[k] <= dl[k-1];
        end
      end
      assign res[c] = dl[Lat-1];
    end
  end

  assign red_out = res[0];
  assign green_out = res[1];
  assign blue_out = res[2];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word lost");
endmodule

### tb/tb_top.sv
// Testbench for lift_gamma_gain_grade_core: directed table, then random pixels over
// several register settings, checked against a built-in grading predictor.
// Depends on lgg_pkg and the core RTL.
module tb_top;
  import lgg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IdxW-1:0] RegSpare = 2'd3;  // unmapped index, write is dropped
  localparam int NumPhases = 10;
  localparam int PhaseWords = 125;
  localparam int StallLen = 300;

  typedef struct packed {
    logic signed [15:0] r;
    logic signed [15:0] g;
    logic signed [15:0] b;
  } pixel_t;

  typedef struct {
    pixel_t px;
    bit     typed;
    pixel_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] red_in = '0, green_in = '0, blue_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] red_out, green_out, blue_out;

  lift_gamma_gain_grade_core u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .red_in, .green_in, .blue_in,
    .out_valid, .out_ready, .red_out, .green_out, .blue_out
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  // log2 / exp2 segment endpoints, Q16
  const longint LogPts[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                               42196, 45904, 49472, 52911, 56228, 59434, 62534, 65536};
  const longint ExpPts[17] = '{65536, 68438, 71468, 74631, 77936, 81386, 84989, 88752,
                               92682, 96785, 101070, 105545, 110218, 115098, 120194,
                               125515, 131072};

  logic [RegW-1:0] lift_shadow, gain_shadow, gamma_shadow;
  pixel_t graded_q[$];
  int errors = 0;
  int mismatches = 0;
  bit no_gaps = 1'b0;

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint gamma_power(longint v, longint gam);
    longint m, f, lg, y, n, t, e, s, i, r, j, q;
    int p;
    p = 0;
    while (p < 14 && (v >>> (p + 1)) != 0) p++;
    m = v << (15 - p);
    f = m - 32768;
    i = (f >>> 11) & 15;
    r = f & 2047;
    lg = (p - FracBits) * 65536 + LogPts[i] + (((LogPts[i+1] - LogPts[i]) * r) >>> 11);
    if (lg >= 0) y = (lg * 4096) / gam;
    else y = -((-lg * 4096 + gam - 1) / gam);
    n = y >>> 16;
    t = y - n * 65536;
    j = (t >>> 12) & 15;
    q = t & 4095;
    e = ExpPts[j] + (((ExpPts[j+1] - ExpPts[j]) * q) >>> 12);
    s = n + FracBits - 16;
    if (s >= 0) begin
      if (s > 15) return 32767;
      return clamp16(e << s);
    end
    s = -s;
    if (s >= 40) return 0;
    return clamp16((e + (longint'(1) << (s - 1))) >>> s);
  endfunction

  function automatic logic [15:0] grade_lane(logic signed [15:0] x, int c);
    longint v, lift, gain, gam, acc;
    v = x;
    lift = $signed(lift_shadow[16*c +: 16]);
    gain = $signed(gain_shadow[16*c +: 16]);
    gam = gamma_shadow[16*c +: 16];
    acc = v * gain + lift * (4096 - v);
    v = clamp16((acc + 2048) >>> FracBits);
    if (v > 0 && gam > 0) v = gamma_power(v, gam);
    return v[15:0];
  endfunction

  function automatic pixel_t grade_pixel(pixel_t px);
    pixel_t o;
    o.r = grade_lane(px.r, 0);
    o.g = grade_lane(px.g, 1);
    o.b = grade_lane(px.b, 2);
    return o;
  endfunction

  task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      RegLift: lift_shadow = val;
      RegGain: gain_shadow = val;
      RegGamma: gamma_shadow = val;
      default: ;
    endcase
  endtask

  // Offer one word, hold until taken, queue its expectation.
  task automatic send_pixel(pixel_t px, bit typed, pixel_t want);
    int gap;
    in_valid <= 1'b1;
    red_in <= px.r;
    green_in <= px.g;
    blue_in <= px.b;
    do @(posedge clk); while (!in_ready);
    graded_q.push_back(typed ? want : grade_pixel(px));
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(0, 9) < 6) return 16'($urandom_range(0, 8191));
    return 16'($urandom);
  endfunction

  function automatic logic [RegW-1:0] rand_reg();
    return RegW'({$urandom, $urandom});
  endfunction

  // Receiver: random stalls, one long hold-off to back the pipeline up
  initial begin
    int gap, taken;
    taken = 0;
    @(negedge rst);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (taken == 400) gap = StallLen;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (graded_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h %h %h", red_out, green_out, blue_out);
      end else begin
        pixel_t want;
        want = graded_q.pop_front();
        if (want.r !== red_out || want.g !== green_out || want.b !== blue_out) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %h %h %h got %h %h %h",
                     want.r, want.g, want.b, red_out, green_out, blue_out);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    pixel_t px, none;
    logic [RegW-1:0] lv, gv, mv;
    none = '0;
    lift_shadow = '0;
    gain_shadow = {3{16'h1000}};
    gamma_shadow = {3{16'h1000}};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Non-positive values bypass the power step at reset settings.
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1, '{16'sd0, 16'sd0, 16'sd0}});
    rows.push_back('{'{-16'sd32768, -16'sd1, -16'sd4096}, 1,
                     '{-16'sd32768, -16'sd1, -16'sd4096}});
    rows.push_back('{'{16'sd32767, 16'sd1, 16'sd4096}, 0, none});
    rows.push_back('{'{16'sd2048, 16'sd8192, 16'sd16384}, 0, none});
    rows.push_back('{'{16'sd3, 16'sd4095, 16'sd4097}, 0, none});
    rows.push_back('{'{16'sd100, -16'sd100, 16'sd32000}, 0, none});
    rows.push_back('{'{16'h5555, 16'h2AAA, 16'h7FFE}, 0, none});
    foreach (rows[k]) send_pixel(rows[k].px, rows[k].typed, rows[k].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Drop valid first so the last word is not offered again while draining.
      in_valid <= 1'b0;
      wait (graded_q.size() == 0);
      repeat (50) @(posedge clk);
      case (ph)
        0: begin lv = '0; gv = {3{16'h1000}}; mv = '0; end  // power step off
        1: begin lv = {3{16'h8000}}; gv = {3{16'h7FFF}}; mv = {3{16'hFFFF}}; end
        2: begin lv = {3{16'h7FFF}}; gv = {3{16'h8000}}; mv = {3{16'h0001}}; end
        3: begin lv = '0; gv = {3{16'h1000}}; mv = {16'h0002, 16'h0800, 16'h4000}; end
        4: begin
          lv = {3{16'($urandom_range(0, 255) - 128)}};
          gv = {16'(16'h1000 + $urandom_range(0, 1023)), 16'h0E00, 16'h1200};
          mv = {16'(16'h0800 + $urandom_range(0, 4095)), 16'h1800, 16'h2000};
        end
        default: begin lv = rand_reg(); gv = rand_reg(); mv = rand_reg(); end
      endcase
      write_reg(RegLift, lv);
      write_reg(RegGain, gv);
      write_reg(RegGamma, mv);
      write_reg(RegSpare, rand_reg());
      cfg_we <= 1'b0;
      no_gaps = (ph % 4 == 1);
      for (int k = 0; k < PhaseWords; k++) begin
        px.r = rand_sample();
        px.g = rand_sample();
        px.b = rand_sample();
        send_pixel(px, 1'b0, none);
      end
    end
    in_valid <= 1'b0;
    wait (graded_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && graded_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
